[design/assert_macros.svh]
// assertion macros, included by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/gsrm_pkg.sv]
// package: commands, field widths and shared types of the goal matcher
package gsrm_pkg;
	localparam logic [1:0] CMD_LOAD_ELEM = 2'd0;
	localparam logic [1:0] CMD_LOAD_HDR  = 2'd1;
	localparam logic [1:0] CMD_STEP      = 2'd2;
	localparam logic [1:0] CMD_CLEAR     = 2'd3;

	localparam int MAX_GOALS       = 64;
	localparam int MAX_PATTERN_LEN = 8;

	localparam int CODE_W   = 10;
	localparam int REWARD_W = 24;
	localparam int STEP_W   = 32;
	localparam int SREW_W   = 30;
	localparam int TOTAL_W  = 40;
	localparam int HITS_W   = 7;
	localparam int RT_W     = 16;
	localparam int GC_W     = 7;

	localparam logic [0:0] CFG_GOAL_COUNT    = 1'd0;
	localparam logic [0:0] CFG_RECOVERY_TIME = 1'd1;

	typedef logic [CODE_W-1:0] code_t;

	// control from the sequencer to the divider
	typedef struct packed {
		logic            start;
		logic [47:0]     dividend;
		logic [RT_W-1:0] divisor;
	} div_req_t;
endpackage

[design/gsrm_hist_cell.sv]
// one history cell: holds one past action and passes it to its neighbor
module gsrm_hist_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  logic               clear,
	input  gsrm_pkg::code_t    din,
	output gsrm_pkg::code_t    dout
);
	import gsrm_pkg::*;
	code_t val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (clear) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= din;
		end
	end
	assign dout = val_q;
endmodule

[design/gsrm_div.sv]
// restoring divider, one quotient bit per cycle
module gsrm_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gsrm_pkg::div_req_t    req,
	output logic                  done,
	output logic [47:0]           quotient
);
	import gsrm_pkg::*;
	logic [47:0]     num_q;
	logic [RT_W:0]   rem_q;
	logic [RT_W-1:0] den_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic [RT_W:0]   trial;
	logic [RT_W:0]   diff;

	assign trial = {rem_q[RT_W-1:0], num_q[47]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd47;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[RT_W]) begin
				rem_q <= diff;
				num_q <= {num_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[46:0], 1'b0};
			end
		end
	end

	assign done     = busy_q && (cnt_q == 6'd0);
	assign quotient = (!diff[RT_W]) ? {num_q[46:0], 1'b1} : {num_q[46:0], 1'b0};
endmodule

[design/goal_sequence_reward_matcher_core.sv]
// top level: goal table, history cell chain, goal scan sequencer and output register
//
// Usage: items enter on s_axis_*: tuser carries the command, tlast final_action and
// tdata goal_index[5:0], element_index[8:6], action_bit[17:9], action_direction[18],
// goal_length[22:19], goal_reward[46:23]. Load and clear items leave the scan idle
// and give no result. An action step gives one result on m_axis_* (tdata:
// step_reward[29:0], total_reward[69:30], goals_hit[76:70], step_number[108:77];
// tlast: run_done).
// An action step walks all goals in use one at a time, each through table read,
// compare, check and accumulate, with a wait on the divider for each goal hit
// inside its recovery time. The result is registered in the output register, and
// the next item is taken once the step is done; one item is worked at a time.
// Reset clears history, counters, hit flags and config (goal_count 0,
// recovery_time 1); the goal table is undefined until loaded, no clearing pass.
// When the receiver stalls the result waits in the output register, and the
// next item is accepted, but its result waits until the register frees.
// Config: cfg_valid/cfg_ready write cfg_index (0 goal_count, 1 recovery_time).
module goal_sequence_reward_matcher_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,   // goal_index, element_index, action_bit,
	                                     // action_direction, goal_length, goal_reward
	input  logic [1:0]   s_axis_tuser,   // command
	input  logic         s_axis_tlast,   // final_action
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,   // step_reward, total_reward, goals_hit, step_number
	output logic         m_axis_tlast,   // run_done
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import gsrm_pkg::*;
	localparam int GW = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
	localparam int PW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_ADD  = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	// input fields
	logic [1:0]  in_cmd;
	logic [5:0]  in_gidx;
	logic [2:0]  in_eidx;
	code_t       in_code;
	logic [3:0]  in_len;
	logic [23:0] in_rew;
	logic        in_fin;
	assign in_cmd  = s_axis_tuser;
	assign in_gidx = s_axis_tdata[5:0];
	assign in_eidx = s_axis_tdata[8:6];
	assign in_code = {s_axis_tdata[18], s_axis_tdata[17:9]};
	assign in_len  = s_axis_tdata[22:19];
	assign in_rew  = s_axis_tdata[46:23];
	assign in_fin  = s_axis_tlast;

	logic [2:0]        state_q;
	logic [GC_W-1:0]   goal_count_q;
	logic [RT_W-1:0]   rt_q;
	logic [STEP_W-1:0] step_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SREW_W-1:0] srew_q;
	logic [HITS_W-1:0] hits_q;
	logic              fin_q;
	logic [GW:0]       g_q;
	logic [GW:0]       count;
	logic [MAX_GOALS-1:0] seen_q;
	logic              out_v_q;
	logic [111:0]      out_q;
	logic              out_last_q;
	logic              acc;

	// goal table memories
	logic [3:0]              len_mem [MAX_GOALS];
	logic [REWARD_W-1:0]     rew_mem [MAX_GOALS];
	logic [STEP_W-1:0]       last_mem [MAX_GOALS];
	code_t                   pat_mem [MAX_GOALS][MAX_PATTERN_LEN];
	logic [3:0]              len_s1;
	logic [REWARD_W-1:0]     rew_s1;
	logic [STEP_W-1:0]       last_s1;
	code_t                   pat_s1 [MAX_PATTERN_LEN];
	logic                    hit_s2;
	logic [REWARD_W-1:0]     rew_s2;
	logic [STEP_W-1:0]       delta_s2;
	logic                    part_s2;
	logic [REWARD_W-1:0]     gain_q;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign count = (goal_count_q > GC_W'(MAX_GOALS)) ? (GW+1)'(MAX_GOALS)
		: (GW+1)'(goal_count_q);

	// history cell chain
	code_t hist [MAX_PATTERN_LEN+1];
	logic  hist_shift;
	logic  run_clear;
	assign hist[0] = in_code;
	assign hist_shift = acc && (in_cmd == CMD_STEP);
	assign run_clear = (acc && (in_cmd == CMD_CLEAR)) || (state_q == ST_OUT && fin_q);
	genvar c;
	generate
		for (c = 0; c < MAX_PATTERN_LEN; c++) begin : g_cell
			gsrm_hist_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(hist_shift), .clear(run_clear),
				.din(hist[c]), .dout(hist[c+1])
			);
		end
	endgenerate

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (acc && in_cmd == CMD_LOAD_HDR && 32'(in_gidx) < MAX_GOALS) begin
			len_mem[GW'(in_gidx)] <= in_len;
			rew_mem[GW'(in_gidx)] <= in_rew;
		end
		if (acc && in_cmd == CMD_LOAD_ELEM && 32'(in_gidx) < MAX_GOALS
			&& 32'(in_eidx) < MAX_PATTERN_LEN) begin
			pat_mem[GW'(in_gidx)][PW'(in_eidx)] <= in_code;
		end
		if (state_q == ST_ACC && hit_s2) begin
			last_mem[GW'(g_q)] <= step_q;
		end
		len_s1  <= len_mem[GW'(g_q)];
		rew_s1  <= rew_mem[GW'(g_q)];
		last_s1 <= last_mem[GW'(g_q)];
		pat_s1  <= pat_mem[GW'(g_q)];
	end

	// compare stage
	logic       match;
	logic [3:0] hidx;
	always_comb begin
		match = (len_s1 != 4'd0) && (32'(len_s1) <= MAX_PATTERN_LEN)
			&& (STEP_W'(len_s1) <= step_q);
		hidx = '0;
		for (int e = 0; e < MAX_PATTERN_LEN; e++) begin
			hidx = len_s1 - 4'(e);
			if (e < 32'(len_s1) && pat_s1[e] != hist[hidx]) begin
				match = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			hit_s2   <= match;
			rew_s2   <= rew_s1;
			delta_s2 <= step_q - last_s1;
			part_s2  <= seen_q[GW'(g_q)] && (rt_q != '0) && ((step_q - last_s1) < STEP_W'(rt_q));
		end
	end

	// divider
	div_req_t    dreq;
	logic        ddone;
	logic [47:0] dquot;
	logic [39:0] dprod;
	assign dprod = rew_s2 * delta_s2[RT_W-1:0];
	assign dreq.start    = (state_q == ST_ACC) && hit_s2 && part_s2;
	assign dreq.dividend = {8'b0, dprod};
	assign dreq.divisor  = rt_q;
	gsrm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(dquot));

	logic [SREW_W:0] srew_sum;
	assign srew_sum = (SREW_W+1)'(srew_q) + (SREW_W+1)'(gain_q);
	logic [TOTAL_W:0] tot_sum;
	assign tot_sum = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(srew_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			goal_count_q <= '0;
			rt_q <= RT_W'(1);
			step_q <= '0;
			total_q <= '0;
			seen_q <= '0;
			out_v_q <= 1'b0;
			g_q <= '0;
			srew_q <= '0;
			hits_q <= '0;
			fin_q <= 1'b0;
			gain_q <= '0;
			out_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GOAL_COUNT) begin
					goal_count_q <= cfg_data[GC_W-1:0];
				end else begin
					rt_q <= cfg_data;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && in_cmd == CMD_CLEAR) begin
						step_q <= '0;
						total_q <= '0;
						seen_q <= '0;
					end else if (acc && in_cmd == CMD_STEP) begin
						if (step_q != '1) begin
							step_q <= step_q + STEP_W'(1);
						end
						fin_q <= in_fin;
						srew_q <= '0;
						hits_q <= '0;
						g_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= (g_q < count) ? ST_CMP : ST_SUM;
				end
				ST_CMP: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (hit_s2) begin
						seen_q[GW'(g_q)] <= 1'b1;
						if (hits_q != '1) begin
							hits_q <= hits_q + HITS_W'(1);
						end
					end
					if (hit_s2 && part_s2) begin
						state_q <= ST_DIV;
					end else begin
						if (hit_s2) begin
							gain_q <= rew_s2;
						end else begin
							gain_q <= '0;
						end
						g_q <= g_q + (GW+1)'(1);
						state_q <= ST_ADD;
					end
				end
				ST_DIV: begin
					// a partial hit waits for the divider
					if (ddone) begin
						gain_q <= dquot[REWARD_W-1:0];
						g_q <= g_q + (GW+1)'(1);
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					srew_q <= srew_sum[SREW_W] ? '1 : srew_sum[SREW_W-1:0];
					gain_q <= '0;
					state_q <= ST_READ;
				end
				ST_SUM: begin
					if (!out_v_q || m_axis_tready) begin
						total_q <= tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
						out_q <= {3'b0, step_q, hits_q,
							(tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0]),
							srew_q};
						out_last_q <= fin_q;
						out_v_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (fin_q) begin
						step_q <= '0;
						total_q <= '0;
						seen_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tlast  = out_last_q;

	`include "assert_macros.svh"
	`ASSERT_IMP(a_idle_ready, clk, arst_n, state_q != ST_IDLE, !s_axis_tready, "busy but ready")
	`ASSERT_NEXT(a_step_starts, clk, arst_n, acc && in_cmd == CMD_STEP, state_q == ST_READ, "step not started")
	`ASSERT_IMP(a_div_only_div, clk, arst_n, dreq.start, rt_q != '0, "divide by zero")
endmodule

[dv/goal_sequence_reward_matcher_core_tb.sv]
// testbench: goal table loads, action steps and reward scoring checked against a local model
`timescale 1ns / 1ps

module goal_sequence_reward_matcher_core_tb;
	import gsrm_pkg::*;

	localparam int N_GOALS   = 64;
	localparam int PAT_LEN   = 8;
	localparam int DRAIN_CYC = 3400;
	localparam int WDOG_MAX  = 20000;

	typedef struct packed {
		logic        fin;
		logic [23:0] reward;
		logic [3:0]  length;
		logic        dir;
		logic [8:0]  abit;
		logic [2:0]  elem;
		logic [5:0]  goal;
		logic [1:0]  cmd;
	} item_t;

	typedef struct packed {
		logic        done;
		logic [31:0] step_no;
		logic [6:0]  hits;
		logic [39:0] total;
		logic [29:0] step_rew;
	} score_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [15:0]  cfg_data;

	goal_sequence_reward_matcher_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// scoring model state
	logic [3:0]  goal_len_tbl [N_GOALS];
	logic [23:0] goal_rew_tbl [N_GOALS];
	logic [9:0]  goal_pat_tbl [N_GOALS*PAT_LEN];
	logic [9:0]  action_hist  [PAT_LEN];
	logic [31:0] last_hit_at  [N_GOALS];
	logic        goal_scored  [N_GOALS];
	logic [31:0] step_count;
	longint unsigned run_total;
	int unsigned goals_in_use;
	int unsigned recovery_steps;

	score_t expected_scores [$];
	int     errors;
	bit     no_idle;
	int     rx_hold;
	int     quiet_cycles;
	logic [9:0] code_pool [6];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic clear_run_model();
		for (int i = 0; i < PAT_LEN; i++) action_hist[i] = '0;
		for (int g = 0; g < N_GOALS; g++) goal_scored[g] = 1'b0;
		step_count = '0;
		run_total  = 0;
	endtask

	task automatic score_item(input item_t it);
		score_t      sc;
		longint unsigned step_sum, gain;
		int unsigned hit_cnt, cnt, len;
		logic [31:0] delta;
		bit          ok;
		case (it.cmd)
			CMD_LOAD_ELEM: goal_pat_tbl[it.goal*PAT_LEN + it.elem] = {it.dir, it.abit};
			CMD_LOAD_HDR: begin
				goal_len_tbl[it.goal] = it.length;
				goal_rew_tbl[it.goal] = it.reward;
			end
			CMD_CLEAR: clear_run_model();
			default: begin
				for (int i = PAT_LEN-1; i > 0; i--) action_hist[i] = action_hist[i-1];
				action_hist[0] = {it.dir, it.abit};
				if (step_count != 32'hFFFF_FFFF) step_count++;
				cnt = goals_in_use > N_GOALS ? N_GOALS : goals_in_use;
				step_sum = 0;
				hit_cnt  = 0;
				for (int g = 0; g < cnt; g++) begin
					len = goal_len_tbl[g];
					ok = !(len == 0 || len > PAT_LEN || len > step_count);
					for (int e = 0; ok && e < len; e++)
						if (goal_pat_tbl[g*PAT_LEN + e] != action_hist[len-1-e]) ok = 0;
					if (!ok) continue;
					gain = goal_rew_tbl[g];
					if (goal_scored[g] && recovery_steps != 0) begin
						delta = step_count - last_hit_at[g];
						if (delta < recovery_steps) gain = gain * delta / recovery_steps;
					end
					step_sum += gain;
					if (step_sum > 64'h3FFF_FFFF) step_sum = 64'h3FFF_FFFF;
					if (hit_cnt < 127) hit_cnt++;
					last_hit_at[g] = step_count;
					goal_scored[g] = 1'b1;
				end
				run_total += step_sum;
				if (run_total > 64'hFF_FFFF_FFFF) run_total = 64'hFF_FFFF_FFFF;
				sc.step_rew = step_sum[29:0];
				sc.total    = run_total[39:0];
				sc.hits     = hit_cnt[6:0];
				sc.step_no  = step_count;
				sc.done     = it.fin;
				expected_scores.push_back(sc);
				if (it.fin) clear_run_model();
			end
		endcase
	endtask

	// offers one item; valid stays high after acceptance so items can follow back to back
	task automatic send_item(input item_t it);
		if (!no_idle && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, it.reward, it.length, it.dir, it.abit, it.elem, it.goal};
		s_axis_tuser  <= it.cmd;
		s_axis_tlast  <= it.fin;
		do @(posedge clk); while (!s_axis_tready);
		score_item(it);
		@(negedge clk);
	endtask

	task automatic send_step(input logic [9:0] code, input logic fin);
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.cmd = CMD_STEP;
		{it.dir, it.abit} = code;
		it.fin = fin;
		send_item(it);
	endtask

	task automatic send_clear();
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.cmd = CMD_CLEAR;
		send_item(it);
	endtask

	task automatic load_goal(input int g, input int len, input logic [23:0] rew);
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.cmd = CMD_LOAD_HDR;
		it.goal = 6'(g);
		it.length = 4'(len);
		it.reward = rew;
		send_item(it);
		for (int e = 0; e < len && e < PAT_LEN; e++) begin
			it = item_t'({$urandom, $urandom});
			it.cmd = CMD_LOAD_ELEM;
			it.goal = 6'(g);
			it.elem = 3'(e);
			{it.dir, it.abit} = code_pool[$urandom_range(5)];
			send_item(it);
		end
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		s_axis_tvalid <= 1'b0;
		wait (expected_scores.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_GOAL_COUNT) goals_in_use = val[6:0];
		else recovery_steps = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stalls, plus a counted hold-off when asked
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(99) >= 34);
		end
	end

	always @(posedge clk) begin
		score_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = score_t'({m_axis_tlast, m_axis_tdata[108:0]});
			if (expected_scores.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_scores.pop_front();
				if (got.step_rew !== want.step_rew) begin
					$display("%0t: step_reward exp %h got %h", $time, want.step_rew, got.step_rew);
					errors++;
				end
				if (got.total !== want.total) begin
					$display("%0t: total_reward exp %h got %h", $time, want.total, got.total);
					errors++;
				end
				if (got.hits !== want.hits) begin
					$display("%0t: goals_hit exp %0d got %0d", $time, want.hits, got.hits);
					errors++;
				end
				if (got.step_no !== want.step_no) begin
					$display("%0t: step_number exp %0d got %0d", $time, want.step_no, got.step_no);
					errors++;
				end
				if (got.done !== want.done) begin
					$display("%0t: run_done exp %b got %b", $time, want.done, got.done);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// every goal gets full reward and a one-element pattern: goals matching a step score at once
	task automatic test_step_saturation();
		for (int g = 0; g < N_GOALS; g++) begin
			load_goal(g, 1, 24'hFF_FFFF);
		end
		write_reg(CFG_GOAL_COUNT, 16'd64);
		write_reg(CFG_RECOVERY_TIME, 16'd0);
		send_step(code_pool[0], 1'b0);
		send_step({1'b1, 9'h1FF}, 1'b0);
		send_step(code_pool[0], 1'b1);
	endtask

	// lengths zero and above eight, partial reward, short history, clear, field extremes
	task automatic test_directed_cases();
		load_goal(0, 8, 24'h00_0100);
		load_goal(1, 0, 24'h12_3456);
		load_goal(2, 15, 24'hFF_FFFF);
		load_goal(3, 1, 24'h00_0A00);
		load_goal(4, 9, 24'h00_0001);
		write_reg(CFG_GOAL_COUNT, 16'd5);
		write_reg(CFG_RECOVERY_TIME, 16'd5);
		send_step(code_pool[0], 1'b0);
		send_step({1'b0, 9'h000}, 1'b0);
		for (int i = 0; i < 6; i++) send_step(code_pool[$urandom_range(5)], 1'b0);
		send_clear();
		for (int i = 0; i < 4; i++) send_step(code_pool[$urandom_range(5)], i == 3);
		send_step({1'b1, 9'h1FF}, 1'b0);
	endtask

	task automatic random_items(input int n);
		item_t it;
		int    g, r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 75) begin
				if ($urandom_range(99) < 85) send_step(code_pool[$urandom_range(5)],
					$urandom_range(99) < 8);
				else send_step(10'($urandom), 1'($urandom_range(1)));
			end else if (r < 85) begin
				g = $urandom_range(N_GOALS-1);
				if (goal_len_tbl[g] >= 1 && goal_len_tbl[g] <= PAT_LEN) begin
					it = item_t'({$urandom, $urandom});
					it.cmd  = CMD_LOAD_ELEM;
					it.goal = 6'(g);
					it.elem = 3'($urandom_range(goal_len_tbl[g]-1));
					if ($urandom_range(3) != 0) {it.dir, it.abit} = code_pool[$urandom_range(5)];
					send_item(it);
				end
			end else if (r < 95) begin
				load_goal($urandom_range(N_GOALS-1), $urandom_range(3, 1), 24'($urandom));
			end else begin
				send_clear();
			end
		end
	endtask

	task automatic test_random_settings();
		write_reg(CFG_GOAL_COUNT, 16'd8);
		write_reg(CFG_RECOVERY_TIME, 16'd1);
		random_items(80);
		write_reg(CFG_RECOVERY_TIME, 16'd65535);
		random_items(60);
		no_idle = 1;
		write_reg(CFG_GOAL_COUNT, 16'd3);
		write_reg(CFG_RECOVERY_TIME, 16'd0);
		random_items(50);
		no_idle = 0;
		write_reg(CFG_GOAL_COUNT, 16'd0);
		random_items(15);
		write_reg(CFG_GOAL_COUNT, 16'd6);
		write_reg(CFG_RECOVERY_TIME, 16'd7);
		random_items(70);
		write_reg(CFG_GOAL_COUNT, 16'd127);
		write_reg(CFG_RECOVERY_TIME, 16'd3);
		random_items(15);
	endtask

	// receiver holds off while steps keep coming, so input stalls
	task automatic test_backpressure();
		write_reg(CFG_GOAL_COUNT, 16'd4);
		rx_hold = 3000;
		for (int i = 0; i < 20; i++) send_step(code_pool[$urandom_range(5)], 1'b0);
		random_items(30);
	endtask

	initial begin
		errors = 0;
		no_idle = 0;
		rx_hold = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		goals_in_use = 0;
		recovery_steps = 1;
		clear_run_model();
		for (int i = 0; i < 6; i++) code_pool[i] = {1'(i % 2), 9'(i / 2 + 1)};
		code_pool[0] = {1'b1, 9'h100};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_step_saturation();
		test_directed_cases();
		test_random_settings();
		test_backpressure();
		s_axis_tvalid <= 1'b0;
		wait (expected_scores.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0 && expected_scores.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
